// ----- rtl/rna_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rna_pkg
// shared operation codes for the rational number alu
// ----------------------------------------------------------------------------
package rna_pkg;
   localparam int unsigned FUNC_W = 3;
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD  = 3'd0,
      FUNC_SUB  = 3'd1,
      FUNC_MUL  = 3'd2,
      FUNC_DIV  = 3'd3,
      FUNC_SIMP = 3'd4
   } func_type;
endpackage

// ----- rtl/rational_number_alu_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_number_alu_core
// signed fraction add, subtract, multiply, divide and gcd simplify
// ----------------------------------------------------------------------------
// usage
//   req_ channel carries req_func and two fractions; a transfer happens when
//   req_valid is high and req_stall low. one item is worked at a time.
//   rsp_ channel returns res_num, res_den and zero_den, held while rsp_stall.
//   arithmetic runs through one shared bit-serial unit:
//   add/sub take three products plus a combine step, multiply and divide
//   two products, simplify a euclid gcd made of serial remainders (up to
//   about 1.5*WIDTH steps) and two quotient divides.
//   req_stall is high while an item is in work or its result waits.
//   synchronous reset empties the block; no result is pending after it.
//   results wrap to WIDTH bits and are sign-extended to 32 bits.
// ----------------------------------------------------------------------------
module rational_number_alu_core #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [rna_pkg::FUNC_W-1:0] req_func,
   input  logic signed [31:0]        req_a_num,
   input  logic signed [31:0]        req_a_den,
   input  logic signed [31:0]        req_b_num,
   input  logic signed [31:0]        req_b_den,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_res_num,
   output logic signed [31:0]        rsp_res_den,
   output logic                      rsp_zero_den
);
   import rna_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_COMB,
      ST_GCD, ST_Q0, ST_Q1, ST_FIN, ST_OUT
   } state_type;

   state_type        state_ff;
   logic [2:0]       func_ff;
   logic [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [WIDTH-1:0] p_ff, q_ff, t0_ff, t1_ff;
   logic             wait_ff;
   logic [WIDTH-1:0] rn_ff, rd_ff;

   logic             su_start, su_div, su_done;
   logic [WIDTH-1:0] su_a, su_b, su_res, su_rem;

   logic [WIDTH-1:0] mag_an, mag_ad;
   assign mag_an = an_ff[WIDTH-1] ? -an_ff : an_ff;
   assign mag_ad = ad_ff[WIDTH-1] ? -ad_ff : ad_ff;

   rna_serial_unit #(.WIDTH(WIDTH)) u_serial (
      .clock(clock), .reset(reset), .start(su_start), .div_mode(su_div),
      .op_a(su_a), .op_b(su_b), .done(su_done), .result(su_res), .rem(su_rem)
   );

   always_comb begin
      su_start = 1'b0;
      su_div   = 1'b0;
      su_a     = an_ff;
      su_b     = bd_ff;
      if (!wait_ff) begin
         case (state_ff)
            ST_M0: begin
               su_start = 1'b1;
               su_a = an_ff;
               su_b = (func_ff == FUNC_MUL) ? bn_ff : bd_ff;
            end
            ST_M1: begin
               su_start = 1'b1;
               su_a = (func_ff == FUNC_DIV) ? bn_ff : ad_ff;
               su_b = (func_ff == FUNC_DIV) ? ad_ff : bd_ff;
            end
            ST_M2: begin
               su_start = 1'b1;
               su_a = ad_ff;
               su_b = bn_ff;
            end
            ST_GCD: begin
               su_start = (q_ff != '0);
               su_div = 1'b1;
               su_a = p_ff;
               su_b = q_ff;
            end
            ST_Q0: begin
               su_start = 1'b1;
               su_div = 1'b1;
               su_a = mag_an;
               su_b = p_ff;
            end
            ST_Q1: begin
               su_start = 1'b1;
               su_div = 1'b1;
               su_a = mag_ad;
               su_b = p_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  func_ff <= req_func;
                  an_ff <= req_a_num[WIDTH-1:0];
                  ad_ff <= req_a_den[WIDTH-1:0];
                  bn_ff <= req_b_num[WIDTH-1:0];
                  bd_ff <= req_b_den[WIDTH-1:0];
                  wait_ff <= 1'b0;
                  if (req_func == FUNC_ADD || req_func == FUNC_SUB ||
                      req_func == FUNC_MUL || req_func == FUNC_DIV)
                     state_ff <= ST_M0;
                  else if (req_func == FUNC_SIMP)
                     state_ff <= ST_GCD;
                  else begin
                     rn_ff <= req_a_num[WIDTH-1:0];
                     rd_ff <= req_a_den[WIDTH-1:0];
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_M0, ST_M1, ST_M2, ST_M3: begin
               if (!wait_ff) begin
                  wait_ff <= 1'b1;
               end else if (su_done) begin
                  wait_ff <= 1'b0;
                  case (state_ff)
                     ST_M0: begin
                        t0_ff <= su_res;
                        state_ff <= ST_M1;
                     end
                     ST_M1: begin
                        rd_ff <= su_res;
                        if (func_ff == FUNC_MUL || func_ff == FUNC_DIV) begin
                           rn_ff <= t0_ff;
                           state_ff <= ST_OUT;
                        end else state_ff <= ST_M2;
                     end
                     default: begin
                        t1_ff <= su_res;
                        state_ff <= ST_COMB;
                     end
                  endcase
               end
            end
            ST_COMB: begin
               rn_ff <= (func_ff == FUNC_SUB) ? t0_ff - t1_ff : t0_ff + t1_ff;
               state_ff <= ST_OUT;
            end
            ST_GCD: begin
               // zero term means divisor one, loaded on acceptance
               if (!wait_ff) begin
                  if (q_ff == '0) begin
                     state_ff <= ST_Q0;
                  end else wait_ff <= 1'b1;
               end else if (su_done) begin
                  wait_ff <= 1'b0;
                  p_ff <= q_ff;
                  q_ff <= su_rem;
               end
            end
            ST_Q0: begin
               if (!wait_ff) wait_ff <= 1'b1;
               else if (su_done) begin
                  wait_ff <= 1'b0;
                  rn_ff <= an_ff[WIDTH-1] ? -su_res : su_res;
                  state_ff <= ST_Q1;
               end
            end
            ST_Q1: begin
               if (!wait_ff) wait_ff <= 1'b1;
               else if (su_done) begin
                  wait_ff <= 1'b0;
                  rd_ff <= ad_ff[WIDTH-1] ? -su_res : su_res;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: if (!rsp_stall) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
         // gcd operands are loaded on acceptance of a simplify item
         if (state_ff == ST_IDLE && req_valid && req_func == FUNC_SIMP) begin
            if (req_a_num[WIDTH-1:0] == '0 || req_a_den[WIDTH-1:0] == '0) begin
               p_ff <= WIDTH'(1);
               q_ff <= '0;
            end else begin
               p_ff <= req_a_num[WIDTH-1] ? -req_a_num[WIDTH-1:0]
                                          : req_a_num[WIDTH-1:0];
               q_ff <= req_a_den[WIDTH-1] ? -req_a_den[WIDTH-1:0]
                                          : req_a_den[WIDTH-1:0];
            end
         end
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_OUT);
   assign rsp_res_num  = 32'(signed'(rn_ff));
   assign rsp_res_den  = 32'(signed'(rd_ff));
   assign rsp_zero_den = (rd_ff == '0);

`ifndef NO_ASSERTIONS
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rn_ff) && $stable(rd_ff))
      else $error("result changed while stalled");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   a_idle_unit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !su_start)
      else $error("serial unit started while idle");
`endif
endmodule

// ----- rtl/rna_serial_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rna_serial_unit
// bit-serial multiply (shift-add) and restoring divide, one bit per cycle
// ----------------------------------------------------------------------------
module rna_serial_unit #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             div_mode,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic             done,
   output logic [WIDTH-1:0] result,
   output logic [WIDTH-1:0] rem
);
   localparam int CW = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             mode_ff, mode_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] sh_ff, sh_in;
   logic [WIDTH-1:0] opb_ff, opb_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opb_in  = opb_ff;
      done_in = 1'b0;
      rem_sh  = {acc_ff, sh_ff[WIDTH-1]};
      trial   = rem_sh - {1'b0, opb_ff};
      if (start) begin
         busy_in = 1'b1;
         mode_in = div_mode;
         cnt_in  = CW'(WIDTH);
         acc_in  = '0;
         sh_in   = op_a;
         opb_in  = op_b;
      end else if (busy_ff) begin
         if (mode_ff) begin
            // restoring division: sh holds dividend then quotient
            if (!trial[WIDTH]) begin
               acc_in = trial[WIDTH-1:0];
               sh_in  = {sh_ff[WIDTH-2:0], 1'b1};
            end else begin
               acc_in = rem_sh[WIDTH-1:0];
               sh_in  = {sh_ff[WIDTH-2:0], 1'b0};
            end
         end else begin
            // multiply, low bits only: sh is multiplier shifted right
            if (sh_ff[0]) acc_in = acc_ff + opb_ff;
            sh_in  = sh_ff >> 1;
            opb_in = opb_ff << 1;
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mode_ff <= mode_in;
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      opb_ff  <= opb_in;
   end

   assign done   = done_ff;
   // division: quotient in sh, remainder in acc
   assign result = mode_ff ? sh_ff : acc_ff;
   assign rem    = acc_ff;
endmodule
